@@ rtl/glu_pkg.sv @@
`timescale 1ns / 1ps

package glu_pkg;

  // Operand width in bits; the operands are taken from the low WIDTH bits of the input ports.
  localparam int unsigned WIDTH = 16;
  localparam int unsigned CNT_W = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  localparam int unsigned IN_W  = 16;
  localparam int unsigned DIV_W = 16;
  localparam int unsigned MUL_W = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_SCALE,
    ST_DIV,
    ST_MUL
  } glu_state_e;

endpackage

@@ rtl/gcd_lcm_unit.sv @@
`timescale 1ns / 1ps

// GCD and LCM unit. An item is taken at a rising edge with start_i high and busy_o low.
// Its result is shown on divisor_o and multiple_o for exactly one cycle, marked by done_o.
// The receiver cannot stall the block, so it must take the result in that cycle.
// If either operand is zero, the result shows in the cycle after the item is taken:
// divisor 1 and multiple 0.
// Otherwise the block runs a binary GCD, then a restoring division of the first operand
// by the GCD, then a final multiply. The GCD steps and the division steps share one
// subtractor under a small sequencer, and the multiply uses its own WIDTH by WIDTH
// multiplier, whose product is registered into multiple_o.
// Every GCD step shortens one of the two values by at least one bit. The scale step,
// the division steps and the multiply step follow in that order, and busy_o falls in
// the same cycle in which done_o shows the result.
// A new item may be started in the same cycle in which done_o shows the previous result.
module gcd_lcm_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [glu_pkg::IN_W-1:0]    first_value_i,
  input  logic [glu_pkg::IN_W-1:0]    second_value_i,
  output logic                        done_o,
  output logic [glu_pkg::DIV_W-1:0]   divisor_o,
  output logic [glu_pkg::MUL_W-1:0]   multiple_o
);
  import glu_pkg::*;

  glu_state_e state_q, state_d;

  // Working pair of the GCD. During the division, x holds the GCD and y the partial remainder.
  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] y_q, y_d;
  // This register holds the first operand, then shifts into the quotient first operand / GCD.
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] opb_q, opb_d;
  // This counter counts the common factors of two during the GCD, then the division steps.
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             done_q, done_d;
  logic [DIV_W-1:0] divisor_q, divisor_d;
  logic [MUL_W-1:0] multiple_q, multiple_d;

  // The top bits are zero when WIDTH is above the port width.
  logic [31:0]      ext_a, ext_b;
  logic [WIDTH-1:0] a_in, b_in;

  // This is the one subtractor that the GCD and division steps share. Its top bit is the borrow.
  logic [WIDTH:0]   sub_x, sub_y, sub_r;
  logic             x_gt_y;
  logic [WIDTH:0]   rem_shift;
  logic [2*WIDTH-1:0] prod;

  assign ext_a = 32'(first_value_i);
  assign ext_b = 32'(second_value_i);
  assign a_in  = ext_a[WIDTH-1:0];
  assign b_in  = ext_b[WIDTH-1:0];

  assign x_gt_y    = x_q > y_q;
  assign rem_shift = {y_q, quo_q[WIDTH-1]};
  assign prod      = quo_q * opb_q;

  always_comb begin
    if (state_q == ST_DIV) begin
      sub_x = rem_shift;
      sub_y = {1'b0, x_q};
    end else if (x_gt_y) begin
      sub_x = {1'b0, x_q};
      sub_y = {1'b0, y_q};
    end else begin
      sub_x = {1'b0, y_q};
      sub_y = {1'b0, x_q};
    end
  end

  assign sub_r = sub_x - sub_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    quo_q      <= quo_d;
    opb_q      <= opb_d;
    cnt_q      <= cnt_d;
    divisor_q  <= divisor_d;
    multiple_q <= multiple_d;
  end

  always_comb begin
    state_d    = state_q;
    x_d        = x_q;
    y_d        = y_q;
    quo_d      = quo_q;
    opb_d      = opb_q;
    cnt_d      = cnt_q;
    done_d     = 1'b0;
    divisor_d  = divisor_q;
    multiple_d = multiple_q;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          x_d   = a_in;
          y_d   = b_in;
          quo_d = a_in;
          opb_d = b_in;
          cnt_d = '0;
          if ((a_in == '0) || (b_in == '0)) begin
            divisor_d  = DIV_W'(1);
            multiple_d = '0;
            done_d     = 1'b1;
          end else begin
            state_d = ST_GCD;
          end
        end
      end
      ST_GCD: begin
        // Binary GCD: remove common factors of two, then remove lone factors of two.
        // When both values are odd, replace the larger one by half their difference.
        if (x_q == y_q) begin
          state_d = ST_SCALE;
        end else if (!x_q[0] && !y_q[0]) begin
          x_d   = x_q >> 1;
          y_d   = y_q >> 1;
          cnt_d = cnt_q + CNT_W'(1);
        end else if (!x_q[0]) begin
          x_d = x_q >> 1;
        end else if (!y_q[0]) begin
          y_d = y_q >> 1;
        end else if (x_gt_y) begin
          x_d = sub_r[WIDTH:1];
        end else begin
          y_d = sub_r[WIDTH:1];
        end
      end
      ST_SCALE: begin
        // Restore the common factors of two. The GCD then sits in x.
        x_d     = x_q << cnt_q;
        y_d     = '0;
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        // Restoring division: each step shifts one bit of the first operand into the remainder.
        if (!sub_r[WIDTH]) begin
          y_d = sub_r[WIDTH-1:0];
        end else begin
          y_d = rem_shift[WIDTH-1:0];
        end
        quo_d = {quo_q[WIDTH-2:0], ~sub_r[WIDTH]};
        if (cnt_q == CNT_W'(WIDTH - 1)) begin
          state_d = ST_MUL;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_MUL: begin
        divisor_d  = DIV_W'(x_q);
        multiple_d = MUL_W'(prod);
        done_d     = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign divisor_o  = divisor_q;
  assign multiple_o = multiple_q;

endmodule

@@ tb/gcd_lcm_unit_tb.sv @@
`timescale 1ns / 1ps

module gcd_lcm_unit_tb;

  import glu_pkg::*;

  // The clock runs at 12 ns. The watchdog gives up after this many cycles in which
  // neither an item is taken nor a result is shown. The limit is far longer than the
  // slowest item and a long sender gap together.
  localparam int unsigned HALF_PERIOD  = 6;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned ITEMS_PER_PHASE = 600;

  // One expected result. The operands travel with it, so that a mismatch line can
  // say which item went wrong.
  typedef struct {
    logic [IN_W-1:0]  first_op;
    logic [IN_W-1:0]  second_op;
    logic [DIV_W-1:0] divisor;
    logic [MUL_W-1:0] multiple;
  } gcd_lcm_expect_t;

  // The tracker works out the divisor and the multiple of each item that the block
  // takes and keeps them in order until the matching result comes out.
  class gcd_lcm_tracker;
    gcd_lcm_expect_t pending_results[$];
    int unsigned     error_count = 0;

    task report(input string msg);
      $display("[%0t ns] MISMATCH: %s", $time, msg);
      error_count++;
    endtask

    // Euclid's remainder method on the masked operands. A zero operand gives a
    // divisor of 1 and a multiple of 0, whatever the other operand is.
    function automatic gcd_lcm_expect_t predict_gcd_lcm(input logic [IN_W-1:0] a_in,
                                                        input logic [IN_W-1:0] b_in);
      gcd_lcm_expect_t  res;
      longint unsigned  op_mask;
      longint unsigned  a;
      longint unsigned  b;
      longint unsigned  x;
      longint unsigned  y;
      longint unsigned  r;
      longint unsigned  g;
      longint unsigned  m;
      op_mask = (64'd1 << WIDTH) - 64'd1;
      a = longint'(a_in) & op_mask;
      b = longint'(b_in) & op_mask;
      if (a == 0 || b == 0) begin
        g = 1;
        m = 0;
      end else begin
        x = a;
        y = b;
        while (y != 0) begin
          r = x % y;
          x = y;
          y = r;
        end
        g = x;
        m = (a * b) / g;
      end
      res.first_op  = a_in;
      res.second_op = b_in;
      res.divisor   = g[DIV_W-1:0];
      res.multiple  = m[MUL_W-1:0];
      return res;
    endfunction

    function void note_item(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b);
      pending_results.push_back(predict_gcd_lcm(a, b));
    endfunction

    task check_result(input logic [DIV_W-1:0] divisor, input logic [MUL_W-1:0] multiple);
      gcd_lcm_expect_t exp;
      if (pending_results.size() == 0) begin
        report($sformatf("result %h/%h with no item outstanding", divisor, multiple));
      end else begin
        exp = pending_results.pop_front();
        if (divisor !== exp.divisor)
          report($sformatf("gcd(%0d,%0d): divisor %0d, expected %0d",
                           exp.first_op, exp.second_op, divisor, exp.divisor));
        if (multiple !== exp.multiple)
          report($sformatf("lcm(%0d,%0d): multiple %0d, expected %0d",
                           exp.first_op, exp.second_op, multiple, exp.multiple));
      end
    endtask

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    task flag_leftovers();
      gcd_lcm_expect_t exp;
      while (pending_results.size() != 0) begin
        exp = pending_results.pop_front();
        report($sformatf("no result for item (%0d,%0d)", exp.first_op, exp.second_op));
      end
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start_i;
  logic              busy_o;
  logic [IN_W-1:0]   first_value_i;
  logic [IN_W-1:0]   second_value_i;
  logic              done_o;
  logic [DIV_W-1:0]  divisor_o;
  logic [MUL_W-1:0]  multiple_o;

  gcd_lcm_tracker tracker = new();

  // Chance in percent that the sender idles once more before it offers the next
  // item. Each stimulus phase sets its own value.
  int unsigned sender_idle_pct;

  gcd_lcm_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .first_value_i  (first_value_i),
    .second_value_i (second_value_i),
    .done_o         (done_o),
    .divisor_o      (divisor_o),
    .multiple_o     (multiple_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(HALF_PERIOD) clk_i = ~clk_i;
  end

  // Everything is sampled at the rising edge, before the block's own updates of
  // that edge take effect. A result shown in the same cycle as a new item is taken
  // belongs to the older item, so it is checked first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o)
        tracker.check_result(divisor_o, multiple_o);
      if (start_i && !busy_o)
        tracker.note_item(first_value_i, second_value_i);
    end
  end

  // The watchdog ends the run once the block has gone quiet for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || done_o)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[%0t ns] watchdog: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  // Offers one item and holds it until the block takes it. The task is entered just
  // after a falling edge and returns just after one, so every input changes only at
  // falling edges. While the sender idles, the operand ports carry random values
  // that the block must ignore. When no idle cycle is drawn, start_i stays high
  // straight into the next item with no low cycle in between.
  task automatic send_item(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      start_i        <= 1'b0;
      first_value_i  <= IN_W'($urandom);
      second_value_i <= IN_W'($urandom);
      @(negedge clk_i);
    end
    start_i        <= 1'b1;
    first_value_i  <= a;
    second_value_i <= b;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // Draws one operand pair. Fully random pairs rarely share large factors, so the
  // mix also builds pairs with a known common factor, pairs where one divides the
  // other, powers of two, equal pairs, zeros and values near the top of the range.
  task automatic pick_operands(output logic [IN_W-1:0] a, output logic [IN_W-1:0] b);
    int unsigned g;
    int unsigned sel;
    sel = $urandom_range(11);
    case (sel)
      0, 1, 2: begin
        a = IN_W'($urandom);
        b = IN_W'($urandom);
      end
      3: begin
        a = IN_W'($urandom_range(1, 64));
        b = IN_W'($urandom_range(1, 64));
      end
      4: begin
        g = $urandom_range(1, 255);
        a = IN_W'(g * $urandom_range(1, 255));
        b = IN_W'(g * $urandom_range(1, 255));
      end
      5: begin
        // Shared factors of two push the binary method through its shifting steps.
        a = IN_W'($urandom_range(1, 255) << $urandom_range(0, 8));
        b = IN_W'($urandom_range(1, 255) << $urandom_range(0, 8));
      end
      6: begin
        a = IN_W'($urandom);
        b = a;
      end
      7: begin
        if ($urandom_range(1)) begin
          a = IN_W'($urandom);
          b = '0;
        end else begin
          a = '0;
          b = IN_W'($urandom);
        end
      end
      8: begin
        a = IN_W'(16'hFFFF - $urandom_range(0, 300));
        b = IN_W'(16'hFFFF - $urandom_range(0, 300));
      end
      9: begin
        a = IN_W'($urandom_range(1, 255));
        b = IN_W'(a * $urandom_range(1, 255));
        if ($urandom_range(1)) begin
          g = a;
          a = b;
          b = IN_W'(g);
        end
      end
      10: begin
        a = IN_W'(1) << $urandom_range(0, IN_W - 1);
        b = IN_W'(1) << $urandom_range(0, IN_W - 1);
      end
      default: begin
        a = IN_W'($urandom);
        b = IN_W'($urandom_range(1, 16));
      end
    endcase
  endtask

  initial begin : stimulus
    logic [IN_W-1:0] a;
    logic [IN_W-1:0] b;
    int unsigned     phase;

    rst_ni          = 1'b0;
    start_i         = 1'b0;
    first_value_i   = '0;
    second_value_i  = '0;
    sender_idle_pct = 19;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed items: zero operands on either side and both, equal operands, the
    // ends of the range, coprime and power-of-two pairs, and pairs where one operand
    // divides the other.
    send_item(16'd0,     16'd0);
    send_item(16'd0,     16'd12345);
    send_item(16'd54321, 16'd0);
    send_item(16'hFFFF,  16'd0);
    send_item(16'd1,     16'd1);
    send_item(16'hFFFF,  16'hFFFF);
    send_item(16'd1,     16'hFFFF);
    send_item(16'hFFFF,  16'd1);
    send_item(16'hFFFF,  16'hFFFE);
    send_item(16'd12345, 16'd12345);
    send_item(16'h8000,  16'h8000);
    send_item(16'h8000,  16'h4000);
    send_item(16'h0001,  16'h8000);
    send_item(16'd65521, 16'd65519);
    send_item(16'd48,    16'd18);
    send_item(16'd18,    16'd48);
    send_item(16'hFFFE,  16'h8000);
    send_item(16'hAAAA,  16'h5555);
    send_item(16'd255,   16'd65280);
    send_item(16'd65280, 16'd255);
    send_item(16'd2,     16'd3);
    send_item(16'hF0F0,  16'h0F0F);

    // Three random phases: a lightly idling sender, a mostly idling one, and one
    // that offers a new item every time the block can take it.
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       sender_idle_pct = 19;
        1:       sender_idle_pct = 70;
        default: sender_idle_pct = 0;
      endcase
      repeat (ITEMS_PER_PHASE) begin
        pick_operands(a, b);
        send_item(a, b);
      end
    end

    start_i <= 1'b0;

    // Let the last results come out, then watch a little longer for any stray one.
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    tracker.flag_leftovers();

    if (tracker.error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/glu_pkg.sv
rtl/gcd_lcm_unit.sv
tb/gcd_lcm_unit_tb.sv
